### design/lpd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the limited-pointer directory.
// Has no dependencies; every other design file but lpd_ram imports it.
package lpd_pkg;

  // Field widths of the stream words.
  localparam int REQ_W       = 3;
  localparam int LINE_W      = 10;
  localparam int CHILD_W     = 4;
  localparam int GRANT_W     = 3;
  localparam int MASK_W      = 16;
  localparam int KIND_W      = 2;
  localparam int MAXSH_W     = 5;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;

  // Remainder unit: 16-bit dividend, divisor up to 31.
  localparam int DIV_DW    = 16;
  localparam int DIV_VW    = 5;
  localparam int DIV_CNT_W = 5;

  localparam int          LFSR_W    = 16;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  localparam logic [CFG_IDX_W-1:0] CFG_SHARER_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NON_INCL     = 1'd1;

  localparam logic [REQ_W-1:0] REQ_GETS      = 3'd0;
  localparam logic [REQ_W-1:0] REQ_GETX      = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PUTS      = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PUTX      = 3'd3;
  localparam logic [REQ_W-1:0] REQ_EVICT     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DOWNGRADE = 3'd5;

  localparam logic [GRANT_W-1:0] GRANT_I    = 3'd0;
  localparam logic [GRANT_W-1:0] GRANT_S    = 3'd1;
  localparam logic [GRANT_W-1:0] GRANT_E    = 3'd2;
  localparam logic [GRANT_W-1:0] GRANT_M    = 3'd3;
  localparam logic [GRANT_W-1:0] GRANT_NONE = 3'd4;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INV  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DOWN = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_EVAL,
    ST_DEC,
    ST_VMOD,
    ST_SCAN,
    ST_WR,
    ST_OUT
  } lpd_state_t;

  typedef struct packed {
    logic [MAXSH_W-1:0] sharer_limit;
    logic               non_inclusive;
  } lpd_cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } lpd_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_VW-1:0] rem;
  } lpd_div_rsp_t;

endpackage

### design/lpd_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/lpd_rem_unit.sv
`timescale 1ns / 1ps
// Restoring remainder unit, one dividend bit per cycle.
// Depends on lpd_pkg for the request and response structs.
module lpd_rem_unit
  import lpd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  lpd_div_req_t req,
  output lpd_div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_DW-1:0]    dvd_r, dvd_nxt;
  logic [DIV_VW-1:0]    dvs_r, dvs_nxt;
  logic [DIV_VW-1:0]    rem_r, rem_nxt;
  logic [DIV_VW:0]      trial;
  logic [DIV_VW:0]      diff;

  assign trial = {rem_r, dvd_r[DIV_DW-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_DW);
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // Shift in the next dividend bit and subtract when it fits.
      rem_nxt = (trial >= {1'b0, dvs_r}) ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
      dvd_nxt = {dvd_r[DIV_DW-2:0], 1'b0};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

### design/lpd_ctrl.sv
`timescale 1ns / 1ps
// Request sequencer: entry read-modify-write, victim scan, result register.
// Depends on lpd_pkg; drives lpd_ram and lpd_rem_unit from the top level.
module lpd_ctrl
  import lpd_pkg::*;
#(
  parameter int CHILDREN = 16,
  parameter int LINES    = 1024,
  parameter int CW       = $clog2(CHILDREN + 1),
  parameter int EW       = CHILDREN + CW + 1,
  parameter int AW       = $clog2(LINES)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lpd_cfg_t               cfg,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [REQ_W-1:0]       in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [KIND_W-1:0]      out_tuser,
  output logic                   ram_we,
  output logic [AW-1:0]          ram_waddr,
  output logic [EW-1:0]          ram_wdata,
  output logic                   ram_re,
  output logic [AW-1:0]          ram_raddr,
  input  logic [EW-1:0]          ram_rdata,
  output lpd_div_req_t           div_req,
  input  lpd_div_rsp_t           div_rsp
);

  localparam int IW = $clog2(CHILDREN);

  lpd_state_t state_r, state_nxt;

  logic [REQ_W-1:0]       type_r, type_nxt;
  logic [CHILD_W-1:0]     child_r, child_nxt;
  logic                   have_r, have_nxt;
  logic                   noex_r, noex_nxt;
  logic                   keep_r, keep_nxt;
  logic [AW-1:0]          line_r, line_nxt;
  logic [AW-1:0]          clr_r, clr_nxt;
  logic [CHILDREN-1:0]    vec_r, vec_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   mk_r, mk_nxt;
  logic [GRANT_W-1:0]     grant_r, grant_nxt;
  logic [CHILDREN-1:0]    mask_r, mask_nxt;
  logic                   err_r, err_nxt;
  logic                   down_r, down_nxt;
  logic [MAXSH_W-1:0]     pick_r, pick_nxt;
  logic [MAXSH_W-1:0]     seen_r, seen_nxt;
  logic [IW-1:0]          idx_r, idx_nxt;
  logic [LFSR_W-1:0]      lfsr_r, lfsr_nxt;
  logic                   ovld_r, ovld_nxt;
  logic [OUT_TDATA_W-1:0] odata_r, odata_nxt;
  logic [KIND_W-1:0]      okind_r, okind_nxt;

  // Decision for the entry just read.
  logic                child_ok;
  logic [CHILDREN-1:0] cbit;
  logic                is_sh;
  logic                excl;
  logic                at_limit;
  logic [CHILDREN-1:0] vec_wo;
  logic [CW-1:0]       cnt_dec;
  logic [CW-1:0]       cnt_inc;
  logic                d_err;
  logic                d_scan;
  logic                d_down;
  logic [CHILDREN-1:0] d_vec;
  logic [CW-1:0]       d_cnt;
  logic                d_mk;
  logic [GRANT_W-1:0]  d_grant;
  logic [CHILDREN-1:0] d_mask;

  // Scan step.
  logic                hit;
  logic [CHILDREN-1:0] idx_bit;

  logic [MASK_W-1:0]   mask16;
  logic [KIND_W-1:0]   kind_v;

  assign child_ok = int'(child_r) < CHILDREN;
  assign cbit     = child_ok ? (CHILDREN'(1) << child_r) : '0;
  assign is_sh    = |(vec_r & cbit);
  assign excl     = mk_r && (cnt_r == CW'(1));
  assign at_limit = (cfg.sharer_limit != '0) && (int'(cnt_r) >= int'(cfg.sharer_limit));
  assign vec_wo   = vec_r & ~cbit;
  assign cnt_dec  = cnt_r - CW'(is_sh);
  assign cnt_inc  = cnt_r + CW'(1);

  assign idx_bit = CHILDREN'(1) << idx_r;
  assign hit     = vec_r[idx_r] && (seen_r == pick_r);

  generate
    if (CHILDREN >= MASK_W) begin : g_mask_trunc
      assign mask16 = mask_r[MASK_W-1:0];
    end else begin : g_mask_ext
      assign mask16 = {{(MASK_W - CHILDREN){1'b0}}, mask_r};
    end
  endgenerate

  assign kind_v = (mask16 == '0) ? KIND_NONE :
                  ((type_r == REQ_DOWNGRADE || down_r) ? KIND_DOWN : KIND_INV);

  always_comb begin
    d_err   = 1'b0;
    d_scan  = 1'b0;
    d_down  = 1'b0;
    d_vec   = vec_r;
    d_cnt   = cnt_r;
    d_mk    = mk_r;
    d_grant = GRANT_NONE;
    d_mask  = '0;
    unique case (type_r)
      REQ_GETS: begin
        if (!child_ok) begin
          d_err = 1'b1;
        end else if (cnt_r == '0 && have_r && !noex_r) begin
          d_vec   = cbit;
          d_cnt   = CW'(1);
          d_mk    = 1'b1;
          d_grant = GRANT_E;
        end else if (is_sh) begin
          d_err = 1'b1;
        end else if (excl) begin
          // The exclusive holder is downgraded and the requester joins it.
          d_mask  = vec_r;
          d_down  = 1'b1;
          d_vec   = vec_r | cbit;
          d_cnt   = cnt_inc;
          d_mk    = 1'b0;
          d_grant = GRANT_S;
        end else if (at_limit) begin
          d_scan = 1'b1;
        end else begin
          d_vec   = vec_r | cbit;
          d_cnt   = cnt_inc;
          d_mk    = 1'b0;
          d_grant = GRANT_S;
        end
      end
      REQ_GETX: begin
        if (!child_ok || !have_r || (is_sh && excl)) begin
          d_err = 1'b1;
        end else begin
          d_mask  = (cnt_dec != '0) ? vec_wo : '0;
          d_vec   = cbit;
          d_cnt   = CW'(1);
          d_mk    = 1'b1;
          d_grant = GRANT_M;
        end
      end
      REQ_PUTS, REQ_PUTX: begin
        if (!child_ok || !is_sh || (type_r == REQ_PUTX && !excl)) begin
          d_err = 1'b1;
        end else if (type_r == REQ_PUTX && keep_r) begin
          d_grant = GRANT_E;
        end else begin
          d_vec   = vec_wo;
          d_cnt   = cnt_dec;
          d_mk    = (cnt_dec == '0) ? 1'b0 : mk_r;
          d_grant = GRANT_I;
        end
      end
      REQ_EVICT: begin
        d_mask = (!cfg.non_inclusive && cnt_r != '0) ? vec_r : '0;
        d_vec  = '0;
        d_cnt  = '0;
        d_mk   = 1'b0;
      end
      REQ_DOWNGRADE: begin
        if (excl) begin
          d_mask = vec_r;
          d_mk   = 1'b0;
        end
      end
      default: begin
        d_err = 1'b1;
      end
    endcase
    if (d_err) begin
      d_vec   = vec_r;
      d_cnt   = cnt_r;
      d_mk    = mk_r;
      d_grant = GRANT_NONE;
      d_mask  = '0;
      d_down  = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    type_nxt  = type_r;
    child_nxt = child_r;
    have_nxt  = have_r;
    noex_nxt  = noex_r;
    keep_nxt  = keep_r;
    line_nxt  = line_r;
    clr_nxt   = clr_r;
    vec_nxt   = vec_r;
    cnt_nxt   = cnt_r;
    mk_nxt    = mk_r;
    grant_nxt = grant_r;
    mask_nxt  = mask_r;
    err_nxt   = err_r;
    down_nxt  = down_r;
    pick_nxt  = pick_r;
    seen_nxt  = seen_r;
    idx_nxt   = idx_r;
    lfsr_nxt  = lfsr_r;
    ovld_nxt  = ovld_r && !out_tready;
    odata_nxt = odata_r;
    okind_nxt = okind_r;

    ram_we    = 1'b0;
    ram_waddr = line_r;
    ram_wdata = {mk_r, cnt_r, vec_r};
    ram_re    = 1'b0;
    ram_raddr = line_r;

    div_req.start    = 1'b0;
    div_req.dividend = lfsr_r;
    div_req.divisor  = DIV_VW'(cfg.sharer_limit);

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(LINES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          type_nxt  = in_tuser;
          // LINES is a power of two, so keeping the low bits takes the index
          // modulo LINES.
          line_nxt  = AW'(in_tdata[LINE_W-1:0]);
          child_nxt = in_tdata[LINE_W +: CHILD_W];
          have_nxt  = in_tdata[LINE_W + CHILD_W];
          noex_nxt  = in_tdata[LINE_W + CHILD_W + 1];
          keep_nxt  = in_tdata[LINE_W + CHILD_W + 2];
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        {mk_nxt, cnt_nxt, vec_nxt} = ram_rdata;
        state_nxt = ST_DEC;
      end
      ST_DEC: begin
        if (d_scan) begin
          div_req.start = 1'b1;
          state_nxt     = ST_VMOD;
        end else begin
          vec_nxt   = d_vec;
          cnt_nxt   = d_cnt;
          mk_nxt    = d_mk;
          grant_nxt = d_grant;
          mask_nxt  = d_mask;
          err_nxt   = d_err;
          down_nxt  = d_down;
          state_nxt = ST_WR;
        end
      end
      ST_VMOD: begin
        if (div_rsp.done) begin
          pick_nxt  = div_rsp.rem[MAXSH_W-1:0];
          seen_nxt  = '0;
          idx_nxt   = '0;
          mask_nxt  = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Walk the children in ascending order looking for the picked sharer.
        if (hit) begin
          mask_nxt = idx_bit;
        end
        if (hit || idx_r == IW'(CHILDREN - 1)) begin
          vec_nxt   = (vec_r & ~(hit ? idx_bit : '0)) | cbit;
          cnt_nxt   = hit ? cnt_r : cnt_inc;
          mk_nxt    = 1'b0;
          grant_nxt = GRANT_S;
          err_nxt   = 1'b0;
          down_nxt  = 1'b0;
          state_nxt = ST_WR;
        end else begin
          if (vec_r[idx_r]) begin
            seen_nxt = seen_r + MAXSH_W'(1);
          end
          idx_nxt = idx_r + IW'(1);
        end
      end
      ST_WR: begin
        ram_we    = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ovld_r || out_tready) begin
          ovld_nxt  = 1'b1;
          odata_nxt = OUT_TDATA_W'({err_r, mask16, grant_r});
          okind_nxt = kind_v;
          lfsr_nxt  = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAPS : '0);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      lfsr_r  <= LFSR_SEED;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      lfsr_r  <= lfsr_nxt;
      ovld_r  <= ovld_nxt;
    end
    type_r  <= type_nxt;
    child_r <= child_nxt;
    have_r  <= have_nxt;
    noex_r  <= noex_nxt;
    keep_r  <= keep_nxt;
    line_r  <= line_nxt;
    vec_r   <= vec_nxt;
    cnt_r   <= cnt_nxt;
    mk_r    <= mk_nxt;
    grant_r <= grant_nxt;
    mask_r  <= mask_nxt;
    err_r   <= err_nxt;
    down_r  <= down_nxt;
    pick_r  <= pick_nxt;
    seen_r  <= seen_nxt;
    idx_r   <= idx_nxt;
    odata_r <= odata_nxt;
    okind_r <= okind_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = okind_r;

endmodule

### design/limited_pointer_directory_unit.sv
`timescale 1ns / 1ps
// Limited-pointer MESI directory, one word at a time: each accepted word passes through
// entry read, decode, entry write and the result register, and the next word is taken
// only once its result is registered (which waits while the last result is not taken).
// A GetS at the sharer limit also runs the bit-serial remainder unit and a victim scan.
// After reset a clearing pass zeroes the entry memory while in_tready stays low;
// configuration writes are taken at any time.
module limited_pointer_directory_unit
  import lpd_pkg::*;
#(
  parameter int CHILDREN = 16,
  parameter int LINES    = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // Request stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // line_index[9:0], child_id[13:10], have_exclusive[14], no_exclusive[15],
  // keep_exclusive[16], zero pad[23:17]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // req_type[2:0]
  input  logic [REQ_W-1:0]       in_tuser,
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // child_grant[2:0], inval_mask[18:3], protocol_error[19], zero pad[23:20]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // inval_kind[1:0]
  output logic [KIND_W-1:0]      out_tuser
);

  localparam int CW = $clog2(CHILDREN + 1);
  localparam int EW = CHILDREN + CW + 1;
  localparam int AW = $clog2(LINES);

  logic [MAXSH_W-1:0] max_sh_r, max_sh_nxt;
  logic               non_incl_r, non_incl_nxt;
  lpd_cfg_t           cfg;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  lpd_div_req_t div_req;
  lpd_div_rsp_t div_rsp;

  always_comb begin
    max_sh_nxt   = max_sh_r;
    non_incl_nxt = non_incl_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SHARER_LIMIT: max_sh_nxt   = cfg_wdata;
        CFG_NON_INCL:     non_incl_nxt = cfg_wdata[0];
        default:          max_sh_nxt   = max_sh_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_sh_r   <= '0;
      non_incl_r <= 1'b0;
    end else begin
      max_sh_r   <= max_sh_nxt;
      non_incl_r <= non_incl_nxt;
    end
  end

  assign cfg.sharer_limit  = max_sh_r;
  assign cfg.non_inclusive = non_incl_r;

  lpd_ram #(
    .WIDTH(EW),
    .DEPTH(LINES)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  lpd_rem_unit u_rem (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  lpd_ctrl #(
    .CHILDREN(CHILDREN),
    .LINES   (LINES),
    .CW      (CW),
    .EW      (EW),
    .AW      (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

endmodule
